// ===== rtl/core/pidc_pkg.sv =====
`timescale 1ns / 1ps
package pidc_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEG    = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_INTEG_LIMIT   = 3'd4,
    REG_DRIVE_MIN     = 3'd5,
    REG_DRIVE_MAX     = 3'd6,
    REG_INVERT        = 3'd7
  } cfg_reg_e;

  // Datapath operation selected by the controller.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,
    OP_MUL_I   = 4'd2,
    OP_INTEG   = 4'd3,
    OP_DIV_INI = 4'd4,
    OP_DIV_STP = 4'd5,
    OP_DIV_END = 4'd6,
    OP_MUL_P   = 4'd7,
    OP_MUL_A   = 4'd8,
    OP_MUL_D   = 4'd9,
    OP_FINISH  = 4'd10
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

// ===== rtl/core/pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// Each request steps through the controller states, including the bit-serial
// derivative divider, before the output is valid. Throughput: one item at a
// time; the next request is taken in the cycle after the result is taken.
// Reset (async, active low) clears the integral, the previous error, the
// controller state and the configuration registers to defaults.
module pid_controller_clamped
  import pidc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,  // measurement, setpoint
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [DATA_WIDTH-1:0]   m_axis_tdata,  // drive_value
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]   cfg_data_i
);

  localparam int unsigned W = DATA_WIDTH;

  logic signed [W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic        [W-2:0] sample_period_q, integ_limit_q;
  logic signed [W-1:0] drive_min_q, drive_max_q;
  logic                invert_q;
  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [W-1:0]        drive_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q     <= '0;
      gain_integ_q    <= '0;
      gain_deriv_q    <= '0;
      sample_period_q <= (W-1)'(6554);
      integ_limit_q   <= (W-1)'(100) << FRAC_BITS;
      drive_min_q     <= -(W'(100) << FRAC_BITS);
      drive_max_q     <= W'(100) << FRAC_BITS;
      invert_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_PROP:     gain_prop_q     <= cfg_data_i;
        REG_GAIN_INTEG:    gain_integ_q    <= cfg_data_i;
        REG_GAIN_DERIV:    gain_deriv_q    <= cfg_data_i;
        REG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i[W-2:0];
        REG_INTEG_LIMIT:   integ_limit_q   <= cfg_data_i[W-2:0];
        REG_DRIVE_MIN:     drive_min_q     <= cfg_data_i;
        REG_DRIVE_MAX:     drive_max_q     <= cfg_data_i;
        REG_INVERT:        invert_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pidc_dpath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .measurement_i   (s_axis_tdata[W-1:0]),
    .setpoint_i      (s_axis_tdata[2*W-1:W]),
    .gain_prop_i     (gain_prop_q),
    .gain_integ_i    (gain_integ_q),
    .gain_deriv_i    (gain_deriv_q),
    .sample_period_i (sample_period_q),
    .integ_limit_i   (integ_limit_q),
    .drive_min_i     (drive_min_q),
    .drive_max_i     (drive_max_q),
    .invert_i        (invert_q),
    .drive_value_o   (drive_value)
  );

  assign m_axis_tdata = drive_value;

endmodule

// ===== rtl/core/pidc_ctrl.sv =====
`timescale 1ns / 1ps
module pidc_ctrl
  import pidc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_MUL_I   = 11'b00000000010,
    ST_INTEG   = 11'b00000000100,
    ST_DIV_INI = 11'b00000001000,
    ST_DIV     = 11'b00000010000,
    ST_DIV_END = 11'b00000100000,
    ST_MUL_P   = 11'b00001000000,
    ST_MUL_A   = 11'b00010000000,
    ST_MUL_D   = 11'b00100000000,
    ST_FINISH  = 11'b01000000000,
    ST_OUT     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        cmd_o.op = OP_MUL_I;
        state_d  = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.op = OP_INTEG;
        state_d  = ST_DIV_INI;
      end
      ST_DIV_INI: begin
        cmd_o.op = OP_DIV_INI;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STP;
        if (sts_i.div_done) state_d = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd_o.op = OP_DIV_END;
        state_d  = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd_o.op = OP_MUL_P;
        state_d  = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd_o.op = OP_MUL_A;
        state_d  = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd_o.op = OP_MUL_D;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

endmodule

// ===== rtl/core/pidc_dpath.sv =====
`timescale 1ns / 1ps
module pidc_dpath
  import pidc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  output dp_sts_t                      sts_o,
  input  logic signed [DATA_WIDTH-1:0] measurement_i,
  input  logic signed [DATA_WIDTH-1:0] setpoint_i,
  input  logic signed [DATA_WIDTH-1:0] gain_prop_i,
  input  logic signed [DATA_WIDTH-1:0] gain_integ_i,
  input  logic signed [DATA_WIDTH-1:0] gain_deriv_i,
  input  logic        [DATA_WIDTH-2:0] sample_period_i,
  input  logic        [DATA_WIDTH-2:0] integ_limit_i,
  input  logic signed [DATA_WIDTH-1:0] drive_min_i,
  input  logic signed [DATA_WIDTH-1:0] drive_max_i,
  input  logic                         invert_i,
  output logic signed [DATA_WIDTH-1:0] drive_value_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned PW  = 2 * W + 2;
  // dividend |(e - prev) << F| < 2^(W+1+F); quotient bits needed
  localparam int unsigned NW  = W + 1 + FRAC_BITS;
  localparam int unsigned CW  = $clog2(NW + 1);
  localparam logic signed [PW-1:0] SatHi = PW'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);

  logic signed [W-1:0]  err_q, prev_q, integ_q, deriv_q;
  logic signed [PW-1:0] prod_q, acc_q;
  logic        [NW-1:0] quo_q, num_q;
  logic        [W-1:0]  rem_q;
  logic                 neg_q;
  logic        [CW-1:0] cnt_q;
  logic signed [W-1:0]  y_q;

  logic signed [W:0]    mul_a, mul_b;
  logic signed [PW-1:0] diff, mul_p, fl;
  logic signed [PW-1:0] integ_sum, lim, ddiff, dq, ysum, yneg, ysat;
  logic signed [W-1:0]  y_hi;
  logic        [W-1:0]  dt, rem_sh, rem_sub;
  logic                 rem_ge;

  function automatic logic signed [PW-1:0] sat_f(logic signed [PW-1:0] x);
    if (x > SatHi) return SatHi;
    if (x < SatLo) return SatLo;
    return x;
  endfunction

  assign diff = PW'(setpoint_i) - PW'(measurement_i);
  assign dt   = (sample_period_i == '0) ? W'(1) : W'(sample_period_i);
  assign lim  = PW'({1'b0, integ_limit_i});
  assign fl   = prod_q >>> FRAC_BITS;

  always_comb begin
    mul_a = (W+1)'(gain_prop_i);
    mul_b = (W+1)'(err_q);
    unique case (cmd_i.op)
      OP_MUL_I: begin
        mul_a = (W+1)'(err_q);
        mul_b = (W+1)'(dt);
      end
      OP_MUL_A: begin
        mul_a = (W+1)'(gain_integ_i);
        mul_b = (W+1)'(integ_q);
      end
      OP_MUL_D: begin
        mul_a = (W+1)'(gain_deriv_i);
        mul_b = (W+1)'(deriv_q);
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign integ_sum = PW'(integ_q) + fl;
  assign ddiff     = PW'(err_q) - PW'(prev_q);

  assign rem_sh  = {rem_q[W-2:0], num_q[NW-1]};
  assign rem_ge  = {rem_q[W-1], rem_sh} >= {1'b0, dt};
  assign rem_sub = W'({rem_q[W-1], rem_sh} - {1'b0, dt});

  assign dq   = neg_q ? -PW'(quo_q) : PW'(quo_q);
  assign ysum = acc_q + fl;
  assign yneg = invert_i ? -ysum : ysum;
  assign ysat = sat_f(yneg);
  // max clamp first, min clamp last
  assign y_hi = ($signed(W'(ysat)) > drive_max_i) ? drive_max_i : $signed(W'(ysat));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_INTEG: begin
          if (integ_sum > lim) integ_q <= W'(lim);
          else if (integ_sum < -lim) integ_q <= W'(-lim);
          else integ_q <= W'(integ_sum);
        end
        OP_DIV_INI: cnt_q <= CW'(NW);
        OP_DIV_STP: cnt_q <= cnt_q - CW'(1);
        OP_DIV_END: prev_q <= err_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: err_q <= W'(sat_f(diff));
      OP_MUL_I, OP_MUL_P: prod_q <= mul_p;
      OP_DIV_INI: begin
        neg_q <= ddiff[PW-1];
        num_q <= NW'((ddiff[PW-1] ? -ddiff : ddiff) <<< FRAC_BITS);
        rem_q <= '0;
        quo_q <= '0;
      end
      OP_DIV_STP: begin
        num_q <= {num_q[NW-2:0], 1'b0};
        quo_q <= {quo_q[NW-2:0], rem_ge};
        rem_q <= rem_ge ? rem_sub : rem_sh;
      end
      OP_DIV_END: deriv_q <= W'(sat_f(dq));
      OP_MUL_A: begin
        acc_q  <= fl;
        prod_q <= mul_p;
      end
      OP_MUL_D: begin
        acc_q  <= ysum;
        prod_q <= mul_p;
      end
      OP_FINISH: y_q <= (y_hi < drive_min_i) ? drive_min_i : y_hi;
      default: ;
    endcase
  end

  assign sts_o.div_done = (cnt_q == CW'(1));
  assign drive_value_o  = y_q;

endmodule

// ===== rtl/core/pidc_checker.sv =====
`timescale 1ns / 1ps
module pidc_props #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [DATA_WIDTH-1:0] m_axis_tdata
);

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
    else $error("no processing after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind pid_controller_clamped pidc_props #(.DATA_WIDTH(DATA_WIDTH)) u_pidc_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
